// ===== sv/tcpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Table cosine point rotator package
// Shared widths and the quarter-wave cosine table.
// ----------------------------------------------------------------------------
package tcpr_pkg;

   localparam int COORD_BITS = 16;
   localparam int ANGLE_BITS = 9;
   localparam int TRIG_BITS  = 9;   // signed cos/sin, -255..255
   localparam int FRAC_BITS  = 8;
   localparam int TABLE_LAST = 128;

   localparam logic [7:0] COS_QUARTER [0:TABLE_LAST] = '{
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253,
      8'd253, 8'd253, 8'd252, 8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd249, 8'd248,
      8'd247, 8'd247, 8'd246, 8'd245, 8'd244, 8'd243, 8'd242, 8'd241, 8'd240, 8'd239,
      8'd238, 8'd237, 8'd236, 8'd234, 8'd233, 8'd232, 8'd231, 8'd229, 8'd228, 8'd226,
      8'd225, 8'd223, 8'd222, 8'd220, 8'd219, 8'd217, 8'd215, 8'd214, 8'd212, 8'd210,
      8'd208, 8'd207, 8'd205, 8'd203, 8'd201, 8'd199, 8'd197, 8'd195, 8'd193, 8'd191,
      8'd189, 8'd187, 8'd185, 8'd183, 8'd180, 8'd178, 8'd176, 8'd174, 8'd171, 8'd169,
      8'd167, 8'd164, 8'd162, 8'd159, 8'd157, 8'd154, 8'd152, 8'd149, 8'd147, 8'd144,
      8'd142, 8'd139, 8'd136, 8'd134, 8'd131, 8'd128, 8'd126, 8'd123, 8'd120, 8'd117,
      8'd115, 8'd112, 8'd109, 8'd106, 8'd103, 8'd100, 8'd98,  8'd95,  8'd92,  8'd89,
      8'd86,  8'd83,  8'd80,  8'd77,  8'd74,  8'd71,  8'd68,  8'd65,  8'd62,  8'd59,
      8'd56,  8'd53,  8'd50,  8'd47,  8'd44,  8'd41,  8'd37,  8'd34,  8'd31,  8'd28,
      8'd25,  8'd22,  8'd19,  8'd16,  8'd13,  8'd9,   8'd6,   8'd3,   8'd0
   };

   function automatic logic [7:0] cos_lookup(input logic [7:0] idx);
      logic [7:0] val;
      val = 8'd0;
      if (idx <= 8'(TABLE_LAST)) begin
         val = COS_QUARTER[idx];
      end
      return val;
   endfunction

endpackage

// ===== sv/table_cosine_point_rotator.sv =====
// ----------------------------------------------------------------------------
// Table cosine point rotator
// Rotates 2D points by a programmed angle on a 512-step circle.
// ----------------------------------------------------------------------------
// The accepting edge loads the input register; the result register then loads
// once it is free, which raises rsp_valid.
// Throughput: one request per cycle unless stalled; cos/sin are looked up
// once per csr write, so the per-request path is four multipliers, two adds.
// Reset: clears both valid stages and sets the angle to zero (pass-through).
module table_cosine_point_rotator #(
   parameter int COORD_BITS = tcpr_pkg::COORD_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [COORD_BITS-1:0]           req_point_x,
   input  logic signed [COORD_BITS-1:0]           req_point_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [COORD_BITS:0]             rsp_rotated_x,
   output logic signed [COORD_BITS:0]             rsp_rotated_y,
   input  logic                                   csr_wr_en,
   input  logic        [tcpr_pkg::ANGLE_BITS-1:0] csr_wr_data
);

   localparam int TW   = tcpr_pkg::TRIG_BITS;
   localparam int PW   = COORD_BITS + TW;
   localparam int SW   = PW + 1;
   localparam int FRAC = tcpr_pkg::FRAC_BITS;

   // angle decode, done once per csr write
   logic        [7:0]    tb_raw;
   logic        [7:0]    tr_raw;
   logic signed [TW-1:0] tb_pos;
   logic signed [TW-1:0] tr_pos;
   logic signed [TW-1:0] tb_sgn;
   logic signed [TW-1:0] tr_sgn;
   logic signed [TW-1:0] cos_in;
   logic signed [TW-1:0] sin_in;
   logic                 bypass_in;
   logic signed [TW-1:0] cos_ff;
   logic signed [TW-1:0] sin_ff;
   logic                 bypass_ff;

   always_comb begin
      tb_raw    = tcpr_pkg::cos_lookup({1'b0, csr_wr_data[6:0]});
      tr_raw    = tcpr_pkg::cos_lookup(8'(tcpr_pkg::TABLE_LAST) - {1'b0, csr_wr_data[6:0]});
      tb_pos    = $signed({1'b0, tb_raw});
      tr_pos    = $signed({1'b0, tr_raw});
      tb_sgn    = csr_wr_data[8] ? -tb_pos : tb_pos;
      tr_sgn    = csr_wr_data[8] ? -tr_pos : tr_pos;
      cos_in    = csr_wr_data[7] ? -tr_sgn : tb_sgn;
      sin_in    = csr_wr_data[7] ? tb_sgn : tr_sgn;
      bypass_in = (csr_wr_data == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff    <= '0;
         sin_ff    <= '0;
         bypass_ff <= 1'b1;
      end else if (csr_wr_en) begin
         cos_ff    <= cos_in;
         sin_ff    <= sin_in;
         bypass_ff <= bypass_in;
      end
   end

   // pipeline handshake
   logic                          in_valid_ff;
   logic signed [COORD_BITS-1:0]  x_ff;
   logic signed [COORD_BITS-1:0]  y_ff;
   logic                          out_valid_ff;
   logic signed [COORD_BITS:0]    rot_x_ff;
   logic signed [COORD_BITS:0]    rot_y_ff;
   logic                          out_open;
   logic                          in_load;
   logic                          out_load;

   assign out_open  = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_open;
   assign in_load   = req_valid && req_ready;
   assign out_load  = in_valid_ff && out_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_open) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         x_ff <= req_point_x;
         y_ff <= req_point_y;
      end
   end

   // rotate: products, sums, arithmetic shift by the table scale
   logic signed [PW-1:0]         xc;
   logic signed [PW-1:0]         xs;
   logic signed [PW-1:0]         yc;
   logic signed [PW-1:0]         ys;
   logic signed [SW-1:0]         sum_x;
   logic signed [SW-1:0]         sum_y;
   logic signed [SW-1:0]         shr_x;
   logic signed [SW-1:0]         shr_y;
   logic signed [COORD_BITS:0]   rot_x_in;
   logic signed [COORD_BITS:0]   rot_y_in;

   always_comb begin
      xc    = PW'(x_ff) * PW'(cos_ff);
      xs    = PW'(x_ff) * PW'(sin_ff);
      yc    = PW'(y_ff) * PW'(cos_ff);
      ys    = PW'(y_ff) * PW'(sin_ff);
      sum_x = SW'(xc) - SW'(ys);
      sum_y = SW'(xs) + SW'(yc);
      shr_x = sum_x >>> FRAC;
      shr_y = sum_y >>> FRAC;
      if (bypass_ff) begin
         // zero angle: pass the point through, sign-extended
         rot_x_in = {x_ff[COORD_BITS-1], x_ff};
         rot_y_in = {y_ff[COORD_BITS-1], y_ff};
      end else begin
         rot_x_in = shr_x[COORD_BITS:0];
         rot_y_in = shr_y[COORD_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rot_x_ff <= rot_x_in;
         rot_y_ff <= rot_y_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_rotated_x = rot_x_ff;
   assign rsp_rotated_y = rot_y_ff;

endmodule

// ===== sv/tcpr_checker.sv =====
// ----------------------------------------------------------------------------
// Table cosine point rotator port checker
// Watches the top-level ports for pipeline timing and backpressure.
// ----------------------------------------------------------------------------
module tcpr_checker #(
   parameter int COORD_BITS = tcpr_pkg::COORD_BITS
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [COORD_BITS:0]             rsp_rotated_x,
   input logic signed [COORD_BITS:0]             rsp_rotated_y
);

   // reset empties the result stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_rotated_x) && $stable(rsp_rotated_y))
      else $error("stalled result changed");

   // an accepted request reaches the output when the output drains
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("accepted request did not reach the output");

   // drop ready only when the output is full and stalled
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without output backpressure");

endmodule

bind table_cosine_point_rotator tcpr_checker #(.COORD_BITS(COORD_BITS)) u_tcpr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_rotated_x (rsp_rotated_x),
   .rsp_rotated_y (rsp_rotated_y)
);

// ===== dv/table_cosine_point_rotator_tb.sv =====
// ----------------------------------------------------------------------------
// Table cosine point rotator testbench
// Drives points through the rotator at a series of programmed angles and
// checks every rotated point against a pinned result or a rotation computed
// here from the quarter-wave cosine table. A short directed table covers the
// corners: pass-through, each quadrant boundary and the coordinate extremes.
// The random phases that follow use bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module table_cosine_point_rotator_tb;

   localparam int W  = tcpr_pkg::COORD_BITS;
   localparam int AW = tcpr_pkg::ANGLE_BITS;
   localparam int FB = tcpr_pkg::FRAC_BITS;
   localparam int QUARTER = tcpr_pkg::TABLE_LAST;

   localparam int DIR_ROWS = 18;
   localparam int PHASES = 14;
   localparam int PHASE_ITEMS = 100;

   typedef struct packed {
      logic signed [W:0] rx;
      logic signed [W:0] ry;
   } rotated_type;

   typedef struct packed {
      logic [AW-1:0]       angle;
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic                pinned;
      logic signed [W:0]   ex;
      logic signed [W:0]   ey;
   } dir_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [W-1:0]  req_point_x;
   logic signed [W-1:0]  req_point_y;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [W:0]    rsp_rotated_x;
   logic signed [W:0]    rsp_rotated_y;
   logic                 csr_wr_en;
   logic [AW-1:0]        csr_wr_data;

   // typed-in expectation travels with the request it belongs to
   logic                 pin_flag;
   logic signed [W:0]    pin_x;
   logic signed [W:0]    pin_y;

   rotated_type   rotated_q[$];
   logic [AW-1:0] angle_model;
   logic [AW-1:0] angle_driven;
   int            mismatch_count;
   int            results_seen;
   int            burst_left;

   // directed rows; pinned ones carry their expected result
   dir_row_type dir_rows [0:DIR_ROWS-1] = '{
      '{9'd0,   16'sd0,      16'sd0,      1'b1, 17'sd0,      17'sd0},
      '{9'd0,   16'sd32767,  16'sh8000,   1'b1, 17'sd32767,  -17'sd32768},
      '{9'd0,   -16'sd1,     16'sd1,      1'b1, -17'sd1,     17'sd1},
      '{9'd0,   16'sh8000,   16'sd32767,  1'b1, -17'sd32768, 17'sd32767},
      '{9'd256, 16'sh8000,   16'sh8000,   1'b1, 17'sd32640,  17'sd32640},
      '{9'd256, 16'sd1,      16'sd0,      1'b1, -17'sd1,     17'sd0},
      '{9'd128, 16'sd256,    16'sd0,      1'b1, 17'sd0,      17'sd255},
      '{9'd384, 16'sd256,    16'sd0,      1'b1, 17'sd0,      -17'sd255},
      '{9'd64,  16'sd32767,  16'sh8000,   1'b1, 17'sd46079,  -17'sd1},
      '{9'd1,   16'sd32767,  16'sd32767,  1'b0, 17'sd0,      17'sd0},
      '{9'd127, 16'sh8000,   16'sd32767,  1'b0, 17'sd0,      17'sd0},
      '{9'd129, 16'sd12345,  -16'sd54,    1'b0, 17'sd0,      17'sd0},
      '{9'd255, 16'sh8000,   16'sh8000,   1'b0, 17'sd0,      17'sd0},
      '{9'd257, 16'sd32767,  -16'sd1,     1'b0, 17'sd0,      17'sd0},
      '{9'd383, 16'sd100,    -16'sd100,   1'b0, 17'sd0,      17'sd0},
      '{9'd511, 16'sh8000,   16'sd32767,  1'b0, 17'sd0,      17'sd0},
      '{9'd511, 16'sd32767,  16'sh8000,   1'b0, 17'sd0,      17'sd0},
      '{9'd0,   16'sd5,      -16'sd5,     1'b1, 17'sd5,      -17'sd5}
   };

   logic [AW-1:0] phase_angles [0:9] = '{
      9'd511, 9'd1, 9'd127, 9'd128, 9'd129, 9'd255, 9'd256, 9'd383, 9'd384, 9'd0
   };

   table_cosine_point_rotator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rotated_x (rsp_rotated_x),
      .rsp_rotated_y (rsp_rotated_y),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   function automatic rotated_type rotate_point(input logic [AW-1:0] ang,
                                                input logic signed [W-1:0] px,
                                                input logic signed [W-1:0] py);
      rotated_type r;
      longint      xl, yl, tb, tr, cs, sn;
      int unsigned b;
      xl = px;
      yl = py;
      if (ang == '0) begin
         r.rx = (W+1)'(xl);
         r.ry = (W+1)'(yl);
         return r;
      end
      b  = ang[AW-3:0];
      tb = longint'(tcpr_pkg::COS_QUARTER[b]);
      tr = longint'(tcpr_pkg::COS_QUARTER[QUARTER - b]);
      // lower half-turn: negate both table values
      if (ang[AW-1]) begin
         tb = -tb;
         tr = -tr;
      end
      if (ang[AW-2]) begin
         cs = -tr;
         sn = tb;
      end else begin
         cs = tb;
         sn = tr;
      end
      r.rx = (W+1)'((xl * cs - yl * sn) >>> FB);
      r.ry = (W+1)'((xl * sn + yl * cs) >>> FB);
      return r;
   endfunction

   function automatic logic signed [W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(W-1){1'b0}}};
         1: return {1'b0, {(W-1){1'b1}}};
         2: return '0;
         3: return '1;
         4: return W'(1);
         default: return W'($urandom());
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic signed [W:0] got,
                                  input logic signed [W:0] want);
      mismatch_count++;
      $display("ERROR %s: got %0d, expected %0d (result %0d)", what, got, want,
               results_seen);
   endtask

   task automatic send_request(input logic signed [W-1:0] x, input logic signed [W-1:0] y,
                               input logic pinned, input logic signed [W:0] ex,
                               input logic signed [W:0] ey);
      @(negedge clock);
      req_valid   = 1'b1;
      req_point_x = x;
      req_point_y = y;
      pin_flag    = pinned;
      pin_x       = ex;
      pin_y       = ey;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold requests back until every rotated point is in, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (rotated_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_angle(input logic [AW-1:0] a);
      drain();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = a;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      angle_driven = a;
   endtask

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   // receiver: random stall windows, plus a long hold-off now and then
   initial begin
      int hold_left;
      int win_left;
      int mode;
      int next_hold_at;
      hold_left    = 0;
      win_left     = 0;
      mode         = 0;
      next_hold_at = 300;
      rsp_ready    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && results_seen >= next_hold_at) begin
            hold_left    = 400;
            next_hold_at = next_hold_at + 600;
         end
         if (win_left == 0) begin
            mode     = $urandom_range(0, 2);
            win_left = $urandom_range(16, 96);
         end
         win_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            case (mode)
               0: rsp_ready = 1'b1;
               1: rsp_ready = ($urandom_range(0, 3) != 0);
               default: rsp_ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rotated_type want;
      if (!reset) begin
         if (csr_wr_en) begin
            angle_model = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            if (pin_flag) begin
               want.rx = pin_x;
               want.ry = pin_y;
            end else begin
               want = rotate_point(angle_model, req_point_x, req_point_y);
            end
            rotated_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rotated_q.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_rotated_x, '0);
            end else begin
               want = rotated_q.pop_front();
               if (rsp_rotated_x !== want.rx) begin
                  report_mismatch("rotated_x", rsp_rotated_x, want.rx);
               end
               if (rsp_rotated_y !== want.ry) begin
                  report_mismatch("rotated_y", rsp_rotated_y, want.ry);
               end
            end
         end
      end
   end

   initial begin
      logic [AW-1:0] a;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_point_x    = '0;
      req_point_y    = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      pin_flag       = 1'b0;
      pin_x          = '0;
      pin_y          = '0;
      angle_model    = '0;
      angle_driven   = '0;
      mismatch_count = 0;
      results_seen   = 0;
      burst_left     = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].angle != angle_driven) begin
            write_angle(dir_rows[i].angle);
         end
         send_request(dir_rows[i].x, dir_rows[i].y, dir_rows[i].pinned,
                      dir_rows[i].ex, dir_rows[i].ey);
      end

      for (int p = 0; p < PHASES; p++) begin
         a = (p < 10) ? phase_angles[p] : AW'($urandom_range(0, (1 << AW) - 1));
         write_angle(a);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // pause once, midway through phase 3, until the pipe is empty
            if (p == 3 && n == PHASE_ITEMS / 2) begin
               drain();
            end
            pace();
            send_request(pick_coord(), pick_coord(), 1'b0, '0, '0);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (rotated_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && rotated_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/tcpr_pkg.sv
sv/table_cosine_point_rotator.sv
sv/tcpr_checker.sv
dv/table_cosine_point_rotator_tb.sv
